### sv/percent_escape_decoder_core_defines.svh
// Assertion macros used by the percent escape decoder checker.
`ifndef PERCENT_ESCAPE_DECODER_CORE_DEFINES_SVH
`define PERCENT_ESCAPE_DECODER_CORE_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define PED_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Checks that a condition in one cycle implies another in the next.
`define PED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ped_pkg.sv
// Types, constants and codes of the percent escape decoder.
`timescale 1ns / 1ps

package ped_pkg;

	localparam logic [7:0]  PERCENT_CHAR     = 8'h25;
	localparam logic [15:0] MAX_OUT_RESET    = 16'd256;
	localparam int          MAX_RES          = 3;
	localparam int          RES_CNT_W        = 2;
	localparam int          FIFO_DEPTH       = 4;
	localparam logic        REG_MAX_OUT_BYTES = 1'b0;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PERCENT = 2'd1,
		PH_DIGIT   = 2'd2
	} ped_phase_t;

	typedef struct packed {
		ped_phase_t  phase;
		logic [7:0]  held;
		logic [15:0] written;
		logic        aborted;
	} ped_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_end;
		logic       overflow;
	} ped_result_t;

	typedef struct packed {
		ped_result_t [MAX_RES-1:0] results;
		logic [RES_CNT_W-1:0]      count;
	} ped_burst_t;

	localparam ped_state_t STATE_CLEAR = '{
		phase:   PH_IDLE,
		held:    8'h00,
		written: 16'h0000,
		aborted: 1'b0
	};

endpackage

### sv/ped_result_fifo.sv
// Result queue: takes a burst of up to three results per cycle, hands out one word a cycle while m_tready is high.
`timescale 1ns / 1ps

module ped_result_fifo #(
	parameter int DEPTH = ped_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  ped_pkg::ped_burst_t burst,
	output logic                space,
	output logic                m_tvalid,
	input  logic                m_tready,
	output ped_pkg::ped_result_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RES_W = ped_pkg::RES_CNT_W;

	ped_pkg::ped_result_t mem_q [DEPTH];
	logic [PW-1:0]        wr_q;
	logic [PW-1:0]        rd_q;
	logic [CW-1:0]        count_q;
	logic [PW-1:0]        wr_idx [ped_pkg::MAX_RES];
	logic [PW-1:0]        wr_next;
	logic [PW-1:0]        rd_next;
	logic [CW-1:0]        push_n;
	logic                 pop;

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
	                                          input logic [CW-1:0] k);
		logic [PW+CW:0] sum;
		sum = (PW+CW+1)'(p) + (PW+CW+1)'(k);
		if (sum >= (PW+CW+1)'(DEPTH)) begin
			sum = sum - (PW+CW+1)'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	assign pop      = m_tvalid && m_tready;
	assign push_n   = push_en ? CW'(burst.count) : '0;
	assign m_tvalid = (count_q != '0);
	assign head     = mem_q[rd_q];
	// Room is judged on the current fill so the worst-case burst always fits.
	assign space    = ((CW+1)'(count_q) + (CW+1)'(ped_pkg::MAX_RES)) <= (CW+1)'(DEPTH);

	always_comb begin
		for (int k = 0; k < ped_pkg::MAX_RES; k++) begin
			wr_idx[k] = wrap_add(wr_q, CW'(k));
		end
		wr_next = wrap_add(wr_q, push_n);
		rd_next = wrap_add(rd_q, CW'(1));
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int k = 0; k < ped_pkg::MAX_RES; k++) begin
				if (RES_W'(k) < burst.count) begin
					mem_q[wr_idx[k]] <= burst.results[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_next;
			if (pop) begin
				rd_q <= rd_next;
			end
			count_q <= count_q + push_n - CW'(pop);
		end
	end

endmodule

### sv/ped_decode.sv
// Per-word decode: escape handling, capacity check and next string state.
`timescale 1ns / 1ps

module ped_decode (
	input  ped_pkg::ped_state_t st,
	input  logic [7:0]          c,
	input  logic                term,
	input  logic [15:0]         max_out,
	output ped_pkg::ped_state_t st_next,
	output ped_pkg::ped_burst_t burst
);

	localparam int NR = ped_pkg::MAX_RES;
	localparam int CW = ped_pkg::RES_CNT_W;

	logic [7:0]          cand [NR];
	logic [CW-1:0]       nb;
	logic                tail;
	ped_pkg::ped_phase_t np;
	logic [7:0]          nh;
	logic [NR-1:0]       ok;
	logic [CW-1:0]       good;
	logic                ovf_push;
	logic [CW-1:0]       used;
	logic                c_pct;
	logic                c_hex;

	function automatic logic is_hex(input logic [7:0] x);
		return (x >= 8'h30 && x <= 8'h39) || (x >= 8'h41 && x <= 8'h46) ||
		       (x >= 8'h61 && x <= 8'h66);
	endfunction

	// Only valid for hex digits: letters of both cases share their low nibble.
	function automatic logic [3:0] hex_nib(input logic [7:0] x);
		if (x <= 8'h39) begin
			return x[3:0];
		end
		return x[3:0] + 4'd9;
	endfunction

	assign c_pct = (c == ped_pkg::PERCENT_CHAR);
	assign c_hex = is_hex(c);

	always_comb begin
		for (int i = 0; i < NR; i++) begin
			cand[i] = 8'h00;
		end
		nb   = '0;
		tail = 1'b0;
		np   = st.phase;
		nh   = st.held;
		if (term) begin
			tail = !st.aborted;
			if (!st.aborted) begin
				case (st.phase)
					ped_pkg::PH_PERCENT: begin
						cand[0] = ped_pkg::PERCENT_CHAR;
						nb      = CW'(1);
					end
					ped_pkg::PH_DIGIT: begin
						cand[0] = ped_pkg::PERCENT_CHAR;
						cand[1] = st.held;
						nb      = CW'(2);
					end
					default: begin
						nb = '0;
					end
				endcase
			end
		end else if (!st.aborted) begin
			case (st.phase)
				ped_pkg::PH_PERCENT: begin
					if (c_hex) begin
						nh = c;
						np = ped_pkg::PH_DIGIT;
					end else begin
						// The lone percent goes out, then the breaking byte is handled afresh.
						cand[0] = ped_pkg::PERCENT_CHAR;
						if (c_pct) begin
							np = ped_pkg::PH_PERCENT;
							nb = CW'(1);
						end else begin
							cand[1] = c;
							np      = ped_pkg::PH_IDLE;
							nb      = CW'(2);
						end
					end
				end
				ped_pkg::PH_DIGIT: begin
					nh = 8'h00;
					if (c_hex) begin
						cand[0] = {hex_nib(st.held), hex_nib(c)};
						np      = ped_pkg::PH_IDLE;
						nb      = CW'(1);
					end else begin
						cand[0] = ped_pkg::PERCENT_CHAR;
						cand[1] = st.held;
						if (c_pct) begin
							np = ped_pkg::PH_PERCENT;
							nb = CW'(2);
						end else begin
							cand[2] = c;
							np      = ped_pkg::PH_IDLE;
							nb      = CW'(3);
						end
					end
				end
				default: begin
					if (c_pct) begin
						np = ped_pkg::PH_PERCENT;
					end else begin
						cand[0] = c;
						np      = ped_pkg::PH_IDLE;
						nb      = CW'(1);
					end
				end
			endcase
		end
	end

	// Byte i of this word fits while written + i + 1 stays below the capacity.
	always_comb begin
		logic found;
		found = 1'b0;
		good  = CW'(NR);
		for (int i = 0; i < NR; i++) begin
			ok[i] = (17'({1'b0, st.written}) + 17'(i + 1)) < 17'({1'b0, max_out});
			if (!ok[i] && !found) begin
				good  = CW'(i);
				found = 1'b1;
			end
		end
		ovf_push = (good < nb);
		used     = ovf_push ? good : nb;
	end

	always_comb begin
		for (int i = 0; i < NR; i++) begin
			burst.results[i] = '{data: 8'h00, is_end: 1'b0, overflow: 1'b0};
			if (CW'(i) < used) begin
				burst.results[i].data = cand[i];
			end else if (CW'(i) == good && ovf_push) begin
				burst.results[i].overflow = 1'b1;
			end else if (CW'(i) == nb && tail) begin
				// With zero capacity the end marker itself does not fit.
				if (max_out == 16'h0000) begin
					burst.results[i].overflow = 1'b1;
				end else begin
					burst.results[i].is_end = 1'b1;
				end
			end
		end
		if (ovf_push) begin
			burst.count = good + CW'(1);
		end else if (tail) begin
			burst.count = nb + CW'(1);
		end else begin
			burst.count = nb;
		end
	end

	always_comb begin
		if (term) begin
			st_next = ped_pkg::STATE_CLEAR;
		end else if (st.aborted) begin
			st_next = st;
		end else if (ovf_push) begin
			st_next.phase   = ped_pkg::PH_IDLE;
			st_next.held    = 8'h00;
			st_next.written = st.written + 16'(used);
			st_next.aborted = 1'b1;
		end else begin
			st_next.phase   = np;
			st_next.held    = nh;
			st_next.written = st.written + 16'(used);
			st_next.aborted = 1'b0;
		end
	end

endmodule

### sv/percent_escape_decoder_core.sv
// An accepted input word is registered in the input stage, then decoded into the result queue.
// Throughput: one input word per cycle while each word yields at most one result and the master
// side is ready; a word's several results leave in turn through the 4-entry result queue.
// Input is taken while the input stage is empty or the queue has room for a burst of three.
// Reset: string state cleared, max_output_bytes back to 256, queue empty; no clearing pass.
`timescale 1ns / 1ps

module percent_escape_decoder_core #(
	parameter int FIFO_DEPTH = ped_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [7:0] in_byte. s_tlast: end_of_string.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	// m_tdata: [7:0] out_byte. m_tlast: is_end. m_tuser: overflow.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	output logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eos_s1;
	ped_pkg::ped_state_t  state_q;
	ped_pkg::ped_state_t  state_next;
	ped_pkg::ped_burst_t  burst;
	ped_pkg::ped_result_t head;
	logic [15:0]          max_q;
	logic                 space;
	logic                 fire;

	assign fire     = valid_s1 && space;
	assign s_tready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	ped_decode u_decode (
		.st      (state_q),
		.c       (byte_s1),
		.term    (eos_s1),
		.max_out (max_q),
		.st_next (state_next),
		.burst   (burst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ped_pkg::STATE_CLEAR;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	ped_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (fire),
		.burst    (burst),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = head.data;
	assign m_tlast = head.is_end;
	assign m_tuser = head.overflow;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= ped_pkg::MAX_OUT_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == ped_pkg::REG_MAX_OUT_BYTES) begin
			max_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == ped_pkg::REG_MAX_OUT_BYTES) ? {16'h0000, max_q} : 32'h0;

endmodule

### sv/ped_checker.sv
// Port-level checker for the percent escape decoder, bound to the top level.
`timescale 1ns / 1ps
`include "percent_escape_decoder_core_defines.svh"

module ped_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// A stalled result word keeps its payload.
	`PED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast, m_tuser}), "result word changed while stalled")

	// A string ends either normally or by overflow, never both in one word.
	`PED_ASSERT(a_end_xor_ovf, !(m_tvalid && m_tlast && m_tuser), "end and overflow set together")

	// Final words carry no byte.
	`PED_ASSERT(a_final_zero, !(m_tvalid && (m_tlast || m_tuser)) || (m_tdata == 8'h00), "final word carries data")

endmodule

bind percent_escape_decoder_core ped_checker u_ped_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
